// ----- hw/rtl/stat_pkg.sv -----
package stat_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH   = 16;
  localparam int unsigned EXPONENT_BITS = 8;

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PAIR_W = 2 * EXPONENT_BITS;
  localparam int unsigned COEF_W = 32;

  // width used to compare a read index against a cell position
  localparam int unsigned RIDX_W = 4;
  localparam int unsigned CMP_W  = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

  // command codes
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_MERGE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  // input word
  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        term_pow_x;
    logic [7:0]        term_pow_y;
    logic signed [31:0] term_coefficient;
    logic [3:0]        read_index;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]         status;
    logic               matched;
    logic               saturated;
    logic [3:0]         entry_index;
    logic [4:0]         term_count;
    logic [7:0]         out_pow_x;
    logic [7:0]         out_pow_y;
    logic signed [31:0] out_coefficient;
  } out_word_t;

  // token passed from cell to cell during a scan
  typedef struct packed {
    logic              vld;
    mode_e             op;
    logic [PAIR_W-1:0] pair;
    logic [COEF_W-1:0] coef;
    logic [RIDX_W-1:0] ridx;
    logic              hit;
    logic              wrote;
    logic              matched;
    logic              sat;
    logic [IDX_W-1:0]  idx;
  } token_t;

endpackage

// ----- hw/rtl/stat_cell.sv -----
module stat_cell import stat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic [CNT_W-1:0] count_i,
  input  token_t           tok_i,
  output token_t           tok_o
);

  // stored term of this position
  logic [PAIR_W-1:0] pair_q, pair_d;
  logic [COEF_W-1:0] coef_q, coef_d;
  token_t            tok_q, tok_d;

  logic                    in_range;
  logic                    do_merge, do_write, do_read;
  logic signed [COEF_W:0]  sum;
  logic                    ovf;
  logic [COEF_W-1:0]       sum_sat;

  // position checks
  assign in_range = CNT_W'(cell_idx_i) < count_i;

  assign do_merge = tok_i.vld && (tok_i.op == MODE_MERGE) && !tok_i.hit &&
                    in_range && (pair_q == tok_i.pair);
  assign do_write = tok_i.vld && !tok_i.hit &&
                    ((tok_i.op == MODE_APPEND) || (tok_i.op == MODE_MERGE)) &&
                    (CNT_W'(cell_idx_i) == count_i);
  assign do_read  = tok_i.vld && (tok_i.op == MODE_READ) && in_range &&
                    (CMP_W'(tok_i.ridx) == CMP_W'(cell_idx_i));

  // saturating coefficient add
  assign sum     = $signed({coef_q[COEF_W-1], coef_q}) +
                   $signed({tok_i.coef[COEF_W-1], tok_i.coef});
  assign ovf     = sum[COEF_W] != sum[COEF_W-1];
  assign sum_sat = !ovf ? sum[COEF_W-1:0] :
                   (sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                : {1'b0, {(COEF_W-1){1'b1}}});

  // entry update and token hand-off
  always_comb begin
    pair_d = pair_q;
    coef_d = coef_q;
    tok_d  = tok_i;
    if (do_merge) begin
      coef_d        = sum_sat;
      tok_d.coef    = sum_sat;
      tok_d.hit     = 1'b1;
      tok_d.matched = 1'b1;
      tok_d.sat     = ovf;
      tok_d.idx     = cell_idx_i;
    end else if (do_write) begin
      pair_d      = tok_i.pair;
      coef_d      = tok_i.coef;
      tok_d.hit   = 1'b1;
      tok_d.wrote = 1'b1;
      tok_d.idx   = cell_idx_i;
    end else if (do_read) begin
      tok_d.pair = pair_q;
      tok_d.coef = coef_q;
      tok_d.hit  = 1'b1;
      tok_d.idx  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
    coef_q <= coef_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- hw/rtl/sparse_term_accumulate_table_core.sv -----
// Sparse two-variable term table. Each term (X power, Y power, signed
// coefficient) sits in one cell of a row of TABLE_DEPTH cells, in insertion
// order. Append, merge and read words send a token down the row, one cell
// per cycle; the cell that matches, is read or is the first free slot acts
// on it. The token goes from the launch register through the register of
// each cell, and its result word is then registered. A clear word gives
// its result on the next cycle. A new word is taken only while no scan is
// running and the result slot is empty or being emptied. Merged sums
// clamp to the signed 32-bit range and raise saturated.
module sparse_term_accumulate_table_core import stat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] count_q, count_d;
  token_t           launch_q, launch_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;
  token_t           chain [TABLE_DEPTH+1];
  token_t           done;
  logic             in_acc;
  logic [CNT_W-1:0] new_count;

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  // cell row
  assign chain[0] = launch_q;
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    stat_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .count_i    (count_q),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end
  assign done = chain[TABLE_DEPTH];

  assign new_count = done.wrote ? count_q + CNT_W'(1) : count_q;

  // command launch, count and result word
  always_comb begin
    busy_d      = busy_q;
    count_d     = count_q;
    launch_d    = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (in_acc) begin
      if (mode_e'(in_data_i.mode) == MODE_CLEAR) begin
        count_d     = '0;
        out_valid_d = 1'b1;
        out_d       = '0;
      end else begin
        busy_d        = 1'b1;
        launch_d.vld  = 1'b1;
        launch_d.op   = mode_e'(in_data_i.mode);
        launch_d.pair = {EXPONENT_BITS'(in_data_i.term_pow_x),
                         EXPONENT_BITS'(in_data_i.term_pow_y)};
        launch_d.coef = in_data_i.term_coefficient;
        launch_d.ridx = in_data_i.read_index;
      end
    end
    if (done.vld) begin
      busy_d      = 1'b0;
      count_d     = new_count;
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.term_count = 5'(new_count);
      if (done.hit) begin
        out_d.status          = STATUS_OK;
        out_d.matched         = done.matched;
        out_d.saturated       = done.sat;
        out_d.entry_index     = 4'(done.idx);
        out_d.out_pow_x       = 8'(done.pair[PAIR_W-1:EXPONENT_BITS]);
        out_d.out_pow_y       = 8'(done.pair[EXPONENT_BITS-1:0]);
        out_d.out_coefficient = done.coef;
      end else if (done.op == MODE_READ) begin
        out_d.status = STATUS_BAD_INDEX;
      end else begin
        out_d.status = STATUS_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      launch_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/stat_checker.sv -----
module stat_checker import stat_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // a dropped term only happens on a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_FULL) |->
      (out_data_o.term_count == 5'(TABLE_DEPTH)))
    else $error("full status with room left");

  // clamping only on a merge hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.matched && (out_data_o.status == STATUS_OK))
    else $error("saturated without a merge hit");

  // a bad read returns an empty entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_BAD_INDEX) |->
      (out_data_o.entry_index == 4'd0) && (out_data_o.out_coefficient == 32'sd0))
    else $error("bad read returned data");

endmodule

bind sparse_term_accumulate_table_core stat_checker u_stat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/term_table_checker.sv -----
`timescale 1ns / 100ps

// watches both channels of the term table, keeps its own copy of the table,
// and compares every result word against the oldest predicted one
module term_table_checker import stat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  // shadow of the term table
  logic [PAIR_W-1:0]        pair_mem [TABLE_DEPTH];
  logic signed [COEF_W-1:0] coef_mem [TABLE_DEPTH];
  int                       term_total;

  out_word_t predicted_results [$];

  // apply one command word to the shadow table and return its result word
  function automatic out_word_t apply_term_word(in_word_t w);
    out_word_t         r;
    logic [PAIR_W-1:0] pair;
    longint            sum;
    int                hit;
    r    = '0;
    pair = {w.term_pow_x[EXPONENT_BITS-1:0], w.term_pow_y[EXPONENT_BITS-1:0]};
    hit  = -1;
    case (mode_e'(w.mode))
      MODE_CLEAR: begin
        term_total = 0;
      end
      MODE_READ: begin
        if (w.read_index < term_total) begin
          r.entry_index     = w.read_index;
          r.out_pow_x       = 8'(pair_mem[w.read_index] >> EXPONENT_BITS);
          r.out_pow_y       = 8'(pair_mem[w.read_index][EXPONENT_BITS-1:0]);
          r.out_coefficient = coef_mem[w.read_index];
        end else begin
          r.status = STATUS_BAD_INDEX;
        end
      end
      default: begin
        // merge looks for the first equal exponent pair
        if (mode_e'(w.mode) == MODE_MERGE) begin
          for (int i = 0; i < term_total; i++) begin
            if (hit < 0 && pair_mem[i] == pair) hit = i;
          end
        end
        if (hit >= 0) begin
          sum = longint'(coef_mem[hit]) + longint'(w.term_coefficient);
          if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            r.saturated = 1'b1;
          end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            r.saturated = 1'b1;
          end
          coef_mem[hit]     = sum[31:0];
          r.matched         = 1'b1;
          r.entry_index     = 4'(hit);
          r.out_pow_x       = 8'(pair >> EXPONENT_BITS);
          r.out_pow_y       = 8'(pair[EXPONENT_BITS-1:0]);
          r.out_coefficient = coef_mem[hit];
        end else if (term_total < TABLE_DEPTH) begin
          pair_mem[term_total] = pair;
          coef_mem[term_total] = w.term_coefficient;
          r.entry_index        = 4'(term_total);
          r.out_pow_x          = 8'(pair >> EXPONENT_BITS);
          r.out_pow_y          = 8'(pair[EXPONENT_BITS-1:0]);
          r.out_coefficient    = w.term_coefficient;
          term_total++;
        end else begin
          r.status = STATUS_FULL;
        end
      end
    endcase
    r.term_count = 5'(term_total);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("field %s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  // result words are checked before the word accepted on the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_total = 0;
      predicted_results.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count_o++;
        end else begin
          out_word_t want;
          want = predicted_results.pop_front();
          check_field("status",          want.status,          out_data_i.status);
          check_field("matched",         want.matched,         out_data_i.matched);
          check_field("saturated",       want.saturated,       out_data_i.saturated);
          check_field("entry_index",     want.entry_index,     out_data_i.entry_index);
          check_field("term_count",      want.term_count,      out_data_i.term_count);
          check_field("out_pow_x",       want.out_pow_x,       out_data_i.out_pow_x);
          check_field("out_pow_y",       want.out_pow_y,       out_data_i.out_pow_y);
          check_field("out_coefficient", want.out_coefficient, out_data_i.out_coefficient);
        end
      end
      if (in_valid_i && in_ready_i) predicted_results.push_back(apply_term_word(in_data_i));
      pending_o <= predicted_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb import stat_pkg::*;;

  localparam int RANDOM_WORDS = 600;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  int fail_count;
  int pending;
  int cycle_count;
  int stall_left;
  int fill_bound;
  int mode_seen [4];
  bit idle_off;

  sparse_term_accumulate_table_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  term_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (idle_off || !rst_ni) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_word_t make_word(mode_e m, int px, int py, logic [31:0] c, int ridx);
    in_word_t w;
    w.mode             = m;
    w.term_pow_x       = 8'(px);
    w.term_pow_y       = 8'(py);
    w.term_coefficient = c;
    w.read_index       = 4'(ridx);
    return w;
  endfunction

  // random word: merges are the most common kind, mostly over a small exponent set so that matches are common
  function automatic in_word_t random_word(int fill);
    in_word_t    w;
    int          pick;
    logic [31:0] c;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0:       c = 32'h7fff_ffff - $urandom_range(0, 3);
      1:       c = 32'h8000_0000 + $urandom_range(0, 3);
      2, 3:    c = $urandom;
      default: c = 32'($signed($urandom_range(0, 200)) - 100);
    endcase
    if ($urandom_range(0, 9) < 7)
      w = make_word(MODE_MERGE, $urandom_range(0, 3), $urandom_range(0, 3), c, $urandom);
    else
      w = make_word(MODE_MERGE, $urandom_range(0, 255), $urandom_range(0, 255), c, $urandom);
    if (pick < 4) begin
      w.mode = MODE_CLEAR;
    end else if (pick < 24) begin
      w.mode = MODE_APPEND;
    end else if (pick >= 70) begin
      w.mode = MODE_READ;
      if ($urandom_range(0, 1) == 0) w.read_index = 4'($urandom_range(0, 15));
      else w.read_index = 4'($urandom_range(0, (fill > 0) ? fill - 1 : 0));
    end
    return w;
  endfunction

  // offer one word and hold it until taken, then maybe idle for a burst
  task automatic send_word(in_word_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    mode_seen[w.mode]++;
    if (mode_e'(w.mode) == MODE_CLEAR) fill_bound = 0;
    else if (mode_e'(w.mode) != MODE_READ && fill_bound < TABLE_DEPTH) fill_bound++;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      // sometimes let the gap start just as the block frees up
      if ($urandom_range(0, 1) == 0) begin
        @(posedge clk_i);
        while (!in_ready) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // hold the sender until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    fill_bound = 0;
    idle_off   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, empty merge, both clamps, duplicates, full table
    send_word(make_word(MODE_CLEAR, 0, 0, 0, 0));
    send_word(make_word(MODE_READ, 0, 0, 0, 0));
    send_word(make_word(MODE_MERGE, 255, 255, 32'h7fff_ffff, 0));
    send_word(make_word(MODE_MERGE, 255, 255, 32'h0000_0001, 0));
    send_word(make_word(MODE_MERGE, 0, 0, 32'h8000_0000, 0));
    send_word(make_word(MODE_MERGE, 0, 0, 32'hffff_ffff, 0));
    send_word(make_word(MODE_APPEND, 0, 0, 32'd5, 0));
    send_word(make_word(MODE_MERGE, 0, 0, 32'd7, 0));
    send_word(make_word(MODE_READ, 0, 0, 0, 2));
    send_word(make_word(MODE_READ, 0, 0, 0, 15));
    for (int i = 0; i < TABLE_DEPTH - 3; i++)
      send_word(make_word(MODE_APPEND, $urandom, $urandom, $urandom, 0));
    send_word(make_word(MODE_APPEND, 1, 2, 32'd3, 0));
    send_word(make_word(MODE_MERGE, 200, 100, 32'd3, 0));
    send_word(make_word(MODE_READ, 0, 0, 0, 15));
    send_word(make_word(MODE_CLEAR, 0, 0, 0, 0));
    wait_drained();

    // random traffic, with a quiet stretch, one drain in the middle and a quiet tail
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idle_off = (n >= 250 && n < 330) || (n >= RANDOM_WORDS - 80);
      if (n == 300) wait_drained();
      send_word(random_word(fill_bound));
    end

    wait_drained();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);

    $display("run covered %0d clear, %0d append, %0d merge and %0d read words",
             mode_seen[MODE_CLEAR], mode_seen[MODE_APPEND],
             mode_seen[MODE_MERGE], mode_seen[MODE_READ]);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/stat_pkg.sv
hw/rtl/stat_cell.sv
hw/rtl/sparse_term_accumulate_table_core.sv
hw/rtl/stat_checker.sv
tb/term_table_checker.sv
tb/tb.sv
